/* design/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants for the speech endpoint detector.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned IndexBitsDefault = 24;
  localparam int unsigned EnergyW          = 24;
  localparam int unsigned ZcrW             = 16;
  localparam int unsigned SilW             = 8;
  localparam int unsigned MinLenW          = 16;
  localparam int unsigned OutW             = 24;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 24;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENERGY_HIGH      = 3'd0,
    CFG_ENERGY_LOW       = 3'd1,
    CFG_ZCR_LOW          = 3'd2,
    CFG_VOICE_ENERGY_FLR = 3'd3,
    CFG_VOICE_ZCR_FLR    = 3'd4,
    CFG_MIN_SILENCE      = 3'd5,
    CFG_MIN_VOICE_LEN    = 3'd6
  } cfg_idx_e;

  localparam logic [EnergyW-1:0] EnergyHighRst = 24'd655360;
  localparam logic [EnergyW-1:0] EnergyLowRst  = 24'd131072;
  localparam logic [ZcrW-1:0]    ZcrLowRst     = 16'd1280;
  localparam logic [SilW-1:0]    MinSilRst     = 8'd6;
  localparam logic [MinLenW-1:0] MinLenRst     = 16'd15;

  typedef enum logic [1:0] {
    PH_SILENCE    = 2'd0,
    PH_TRANSITION = 2'd1,
    PH_VOICE      = 2'd2,
    PH_ENDED      = 2'd3
  } phase_e;

  typedef struct packed {
    logic [EnergyW-1:0] energy_high;
    logic [EnergyW-1:0] energy_low;
    logic [ZcrW-1:0]    zcr_low;
    logic [EnergyW-1:0] voice_energy_floor;
    logic [ZcrW-1:0]    voice_zcr_floor;
    logic [SilW-1:0]    min_silence;
    logic [MinLenW-1:0] min_voice_length;
  } sed_cfg_t;

  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic [ZcrW-1:0]    zcr;
  } sed_in_t;

  typedef struct packed {
    logic [OutW-1:0] segment_begin;
    logic [OutW-1:0] segment_end;
    logic [OutW-1:0] segment_length;
  } sed_out_t;

endpackage

/* design/speech_endpoint_detector.sv */
// ----------------------------------------------------------------------------
// speech_endpoint_detector
// Double-threshold energy / zero-crossing endpoint detector over frame features.
// ----------------------------------------------------------------------------
// Each input beat carries one frame's energy and zero-crossing rate; the block
// takes one frame per cycle and updates its phase machine (silence, transition,
// voice, segment-ended) and counters in that same cycle. On the frame after a
// segment closes, one result beat (begin, end, length) is loaded into the
// output register and appears in the cycle after that frame is taken. Input is
// held off only when a result is still waiting and the current frame would
// produce another. Frame indexes are INDEX_BITS wide and wrap; outputs carry
// their low 24 bits. Configuration is to be written by the user through the cfg
// channel while no frame is in flight; the block itself does not enforce this.
module speech_endpoint_detector #(
  parameter int unsigned INDEX_BITS = sed_pkg::IndexBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sed_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sed_pkg::sed_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sed_pkg::sed_out_t            out_data_o
);
  import sed_pkg::*;

  localparam int unsigned WideW = (INDEX_BITS > OutW) ? INDEX_BITS : OutW;
  localparam logic [INDEX_BITS-1:0] IdxMax = {INDEX_BITS{1'b1}};

  sed_cfg_t cfg;

  sed_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  phase_e                phase_q, phase_d;
  logic [INDEX_BITS-1:0] frame_cnt_q, frame_cnt_d;
  logic [INDEX_BITS-1:0] seg_start_q, seg_start_d;
  logic [INDEX_BITS-1:0] seg_stop_q, seg_stop_d;
  logic [INDEX_BITS-1:0] run_len_q, run_len_d;
  logic [SilW-1:0]       quiet_q, quiet_d;
  logic                  out_valid_q;
  sed_out_t              out_data_q;

  logic                  in_fire;
  logic                  emit;
  logic                  loud;
  logic                  trans;
  logic                  voiced;
  logic [SilW-1:0]       quiet_inc;
  logic [INDEX_BITS-1:0] run_inc;
  logic [WideW-1:0]      run_wide;
  logic [WideW-1:0]      start_wide;
  logic [WideW-1:0]      stop_wide;
  logic [WideW-1:0]      min_len_wide;

  // stall only if a waiting result would be overwritten
  assign in_ready_o = !(phase_q == PH_ENDED && out_valid_q && !out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit       = in_fire && (phase_q == PH_ENDED);

  assign loud   = in_data_i.energy > cfg.energy_high;
  assign trans  = (in_data_i.energy > cfg.energy_low) ||
                  (in_data_i.zcr > cfg.zcr_low);
  assign voiced = (in_data_i.energy > cfg.voice_energy_floor) ||
                  (in_data_i.zcr > cfg.voice_zcr_floor);

  assign run_inc      = (run_len_q != IdxMax) ? run_len_q + 1'b1 : run_len_q;
  assign quiet_inc    = (quiet_q != {SilW{1'b1}}) ? quiet_q + 1'b1 : quiet_q;
  assign run_wide     = WideW'(run_len_q);
  assign min_len_wide = WideW'(cfg.min_voice_length);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (in_fire) begin
      case (phase_q)
        PH_SILENCE, PH_TRANSITION: begin
          if (loud)       phase_d = PH_VOICE;
          else if (trans) phase_d = PH_TRANSITION;
          else            phase_d = PH_SILENCE;
        end
        PH_VOICE: begin
          if (!voiced && !(quiet_inc < cfg.min_silence)) begin
            phase_d = (run_wide < min_len_wide) ? PH_SILENCE : PH_ENDED;
          end
        end
        default: phase_d = PH_SILENCE;
      endcase
    end
  end

  // counters and segment marks
  always_comb begin
    frame_cnt_d = frame_cnt_q;
    seg_start_d = seg_start_q;
    seg_stop_d  = seg_stop_q;
    run_len_d   = run_len_q;
    quiet_d     = quiet_q;
    if (in_fire) begin
      frame_cnt_d = frame_cnt_q + 1'b1;
      case (phase_q)
        PH_SILENCE, PH_TRANSITION: begin
          if (loud) begin
            // saturate the begin index at zero
            seg_start_d = (frame_cnt_q > run_len_q) ? frame_cnt_q - run_len_q - 1'b1 : '0;
            run_len_d   = run_inc;
            quiet_d     = '0;
          end else if (trans) begin
            run_len_d = run_inc;
          end else begin
            run_len_d = '0;
          end
        end
        PH_VOICE: begin
          if (voiced) begin
            run_len_d = run_inc;
          end else begin
            quiet_d = quiet_inc;
            if (quiet_inc < cfg.min_silence) begin
              run_len_d = run_inc;
            end else if (run_wide < min_len_wide) begin
              quiet_d   = '0;
              run_len_d = '0;
            end else begin
              seg_stop_d = seg_start_q + run_len_q;
            end
          end
        end
        default: run_len_d = '0;
      endcase
    end
  end

  assign start_wide = WideW'(seg_start_q);
  assign stop_wide  = WideW'(seg_stop_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SILENCE;
      frame_cnt_q <= '0;
      seg_start_q <= '0;
      seg_stop_q  <= '0;
      run_len_q   <= '0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_cnt_q <= frame_cnt_d;
      seg_start_q <= seg_start_d;
      seg_stop_q  <= seg_stop_d;
      run_len_q   <= run_len_d;
      quiet_q     <= quiet_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.segment_begin  <= start_wide[OutW-1:0];
      out_data_q.segment_end    <= stop_wide[OutW-1:0];
      out_data_q.segment_length <= run_wide[OutW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_ended_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_ENDED) |=> (phase_q == PH_SILENCE && out_valid_o))
    else $error("ended frame did not emit and return to silence");

  a_silence_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SILENCE) |-> (run_len_q == '0))
    else $error("run length nonzero in silence");

  a_emit_from_ended: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o ##1 out_valid_o) |-> $past(phase_q == PH_ENDED && in_fire))
    else $error("result appeared without an ended frame");
`endif

endmodule

/* design/sed_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sed_cfg_regs
// Threshold and limit registers, written one beat at a time by index.
// ----------------------------------------------------------------------------
module sed_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sed_pkg::CfgDataW-1:0] cfg_data_i,
  output sed_pkg::sed_cfg_t            cfg_o
);
  import sed_pkg::*;

  sed_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENERGY_HIGH:      cfg_d.energy_high        = cfg_data_i[EnergyW-1:0];
        CFG_ENERGY_LOW:       cfg_d.energy_low         = cfg_data_i[EnergyW-1:0];
        CFG_ZCR_LOW:          cfg_d.zcr_low            = cfg_data_i[ZcrW-1:0];
        CFG_VOICE_ENERGY_FLR: cfg_d.voice_energy_floor = cfg_data_i[EnergyW-1:0];
        CFG_VOICE_ZCR_FLR:    cfg_d.voice_zcr_floor    = cfg_data_i[ZcrW-1:0];
        CFG_MIN_SILENCE:      cfg_d.min_silence        = cfg_data_i[SilW-1:0];
        CFG_MIN_VOICE_LEN:    cfg_d.min_voice_length   = cfg_data_i[MinLenW-1:0];
        default:              cfg_d = cfg_q; // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.energy_high        <= EnergyHighRst;
      cfg_q.energy_low         <= EnergyLowRst;
      cfg_q.zcr_low            <= ZcrLowRst;
      cfg_q.voice_energy_floor <= '0;
      cfg_q.voice_zcr_floor    <= '0;
      cfg_q.min_silence        <= MinSilRst;
      cfg_q.min_voice_length   <= MinLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* tb/sv/speech_endpoint_detector_test.sv */
// ----------------------------------------------------------------------------
// speech_endpoint_detector_test
// Self-checking bench for the speech endpoint detector. A scoreboard class
// tracks the phase machine and counters frame by frame, queues the segment
// each ended frame reports and compares every output beat field by field.
// A directed run covers threshold edges, begin saturation, tolerated and
// ending silence and dropped segments. Random phases then rewrite all
// registers (reset values, all zero, all ones, longest silence, random) and
// play utterances with random gaps on the input side and stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module speech_endpoint_detector_test;
  import sed_pkg::*;

  typedef enum int {
    FK_SILENT,
    FK_TRANSITION,
    FK_LOUD,
    FK_VOICED,
    FK_HUSH,
    FK_NOISE
  } frame_kind_e;

  localparam logic [23:0] EnergyTop = 24'hFFFFFF;
  localparam logic [23:0] ZcrTop    = 24'h00FFFF;

  class segment_scoreboard;
    sed_cfg_t    regs;
    phase_e      ph;
    logic [23:0] frame_idx;
    logic [23:0] seg_first;
    logic [23:0] seg_last;
    logic [23:0] run_len;
    logic [7:0]  quiet;
    sed_out_t    segments_due[$];
    int          errors;
    int          results_seen;

    function new();
      regs = '{EnergyHighRst, EnergyLowRst, ZcrLowRst, '0, '0, MinSilRst, MinLenRst};
      ph = PH_SILENCE;
      frame_idx = '0;
      seg_first = '0;
      seg_last = '0;
      run_len = '0;
      quiet = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [23:0] val);
      case (idx)
        CFG_ENERGY_HIGH:      regs.energy_high = val;
        CFG_ENERGY_LOW:       regs.energy_low = val;
        CFG_ZCR_LOW:          regs.zcr_low = val[15:0];
        CFG_VOICE_ENERGY_FLR: regs.voice_energy_floor = val;
        CFG_VOICE_ZCR_FLR:    regs.voice_zcr_floor = val[15:0];
        CFG_MIN_SILENCE:      regs.min_silence = val[7:0];
        CFG_MIN_VOICE_LEN:    regs.min_voice_length = val[15:0];
        default: ;
      endcase
    endfunction

    function void extend_run();
      if (run_len != 24'hFFFFFF) run_len++;
    endfunction

    function void note_frame(sed_in_t f);
      sed_out_t seg;
      case (ph)
        PH_SILENCE, PH_TRANSITION: begin
          if (f.energy > regs.energy_high) begin
            // begin sits one frame ahead of the run, clamped at index zero
            seg_first = (frame_idx > run_len) ? frame_idx - run_len - 24'd1 : '0;
            ph = PH_VOICE;
            extend_run();
            quiet = '0;
          end else if (f.energy > regs.energy_low || f.zcr > regs.zcr_low) begin
            ph = PH_TRANSITION;
            extend_run();
          end else begin
            ph = PH_SILENCE;
            run_len = '0;
          end
        end
        PH_VOICE: begin
          if (f.energy > regs.voice_energy_floor ||
              f.zcr > regs.voice_zcr_floor) begin
            extend_run();
          end else begin
            // quiet count survives voiced frames; only open or drop clears it
            if (quiet != 8'hFF) quiet++;
            if (quiet < regs.min_silence) begin
              extend_run();
            end else if (run_len < regs.min_voice_length) begin
              ph = PH_SILENCE;
              quiet = '0;
              run_len = '0;
            end else begin
              ph = PH_ENDED;
              seg_last = seg_first + run_len;
            end
          end
        end
        default: begin
          // ended frame is not evaluated, it only reports the segment
          seg = '{seg_first, seg_last, run_len};
          segments_due = {segments_due, seg};
          run_len = '0;
          ph = PH_SILENCE;
        end
      endcase
      frame_idx++;
    endfunction

    function void check_result(sed_out_t got);
      sed_out_t want;
      results_seen++;
      if (segments_due.size() == 0) begin
        $error("unexpected segment beat: begin %0d end %0d length %0d",
               got.segment_begin, got.segment_end, got.segment_length);
        errors++;
        return;
      end
      want = segments_due.pop_front();
      if (got.segment_begin !== want.segment_begin) begin
        $error("segment_begin: expected %0d, got %0d", want.segment_begin,
               got.segment_begin);
        errors++;
      end
      if (got.segment_end !== want.segment_end) begin
        $error("segment_end: expected %0d, got %0d", want.segment_end, got.segment_end);
        errors++;
      end
      if (got.segment_length !== want.segment_length) begin
        $error("segment_length: expected %0d, got %0d", want.segment_length,
               got.segment_length);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  sed_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sed_out_t            out_data_o;

  segment_scoreboard sb;
  int                frames_sent = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;

  speech_endpoint_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: mostly ready, with random stall runs unless steady
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // observe beats as they cross each channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_frame(in_data_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
    end
  end

  function automatic logic [23:0] pick_above(logic [23:0] t, logic [23:0] top);
    if (t >= top) return top;
    case ($urandom_range(0, 3))
      0:       return t + 24'd1;
      1:       return top;
      default: return 24'($urandom_range(top, t + 24'd1));
    endcase
  endfunction

  function automatic logic [23:0] pick_upto(logic [23:0] t);
    case ($urandom_range(0, 3))
      0:       return t;
      1:       return '0;
      default: return 24'($urandom_range(t, 0));
    endcase
  endfunction

  function automatic sed_in_t make_frame(frame_kind_e kind, sed_cfg_t c);
    sed_in_t     f;
    logic [23:0] lim;
    f = '0;
    case (kind)
      FK_SILENT: begin
        lim = (c.energy_low < c.energy_high) ? c.energy_low : c.energy_high;
        f.energy = pick_upto(lim);
        f.zcr = 16'(pick_upto({8'h0, c.zcr_low}));
      end
      FK_TRANSITION: begin
        if (c.energy_low < c.energy_high && $urandom_range(0, 1) == 1) begin
          f.energy = pick_above(c.energy_low, c.energy_high);
          f.zcr = 16'($urandom);
        end else begin
          f.energy = pick_upto(c.energy_high);
          f.zcr = 16'(pick_above({8'h0, c.zcr_low}, ZcrTop));
        end
      end
      FK_LOUD: begin
        f.energy = pick_above(c.energy_high, EnergyTop);
        f.zcr = 16'($urandom);
      end
      FK_VOICED: begin
        if ($urandom_range(0, 1) == 1) begin
          f.energy = pick_above(c.voice_energy_floor, EnergyTop);
          f.zcr = 16'($urandom);
        end else begin
          f.energy = pick_upto(c.voice_energy_floor);
          f.zcr = 16'(pick_above({8'h0, c.voice_zcr_floor}, ZcrTop));
        end
      end
      FK_HUSH: begin
        f.energy = pick_upto(c.voice_energy_floor);
        f.zcr = 16'(pick_upto({8'h0, c.voice_zcr_floor}));
      end
      default: begin
        f.energy = 24'($urandom);
        f.zcr = 16'($urandom);
      end
    endcase
    return f;
  endfunction

  function automatic sed_cfg_t random_cfg();
    sed_cfg_t c;
    c.energy_high = 24'($urandom);
    c.energy_low = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                               : 24'($urandom_range(c.energy_high, 0));
    c.zcr_low = 16'($urandom);
    c.voice_energy_floor = 24'($urandom_range(c.energy_low, 0));
    c.voice_zcr_floor = 16'($urandom_range(c.zcr_low, 0));
    c.min_silence = 8'($urandom_range(0, 6));
    c.min_voice_length = 16'($urandom_range(0, 12));
    return c;
  endfunction

  task automatic send_frame(input sed_in_t f);
    if (burst_left == 0) begin
      burst_left = tx_steady ? 1000 : $urandom_range(1, 16);
      if (!tx_steady && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= f;
    do @(posedge clk_i); while (!in_ready_o);
    frames_sent++;
  endtask

  task automatic write_config(input sed_cfg_t c);
    cfg_idx_e    idx;
    logic [23:0] junk;
    logic [23:0] val;
    idx = idx.first();
    do begin
      junk = 24'($urandom);
      // upper bits of narrow registers carry junk that must be dropped
      case (idx)
        CFG_ENERGY_HIGH:      val = c.energy_high;
        CFG_ENERGY_LOW:       val = c.energy_low;
        CFG_ZCR_LOW:          val = {junk[7:0], c.zcr_low};
        CFG_VOICE_ENERGY_FLR: val = c.voice_energy_floor;
        CFG_VOICE_ZCR_FLR:    val = {junk[7:0], c.voice_zcr_floor};
        CFG_MIN_SILENCE:      val = {junk[15:0], c.min_silence};
        default:              val = {junk[7:0], c.min_voice_length};
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid_i <= 1'b0;
  endtask

  // hold input, wait for every queued segment, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.segments_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic play_utterance(input sed_cfg_t c);
    int body;
    int tail;
    repeat ($urandom_range(0, 3)) send_frame(make_frame(FK_SILENT, c));
    repeat ($urandom_range(0, 3)) send_frame(make_frame(FK_TRANSITION, c));
    send_frame(make_frame(FK_LOUD, c));
    body = $urandom_range(0, c.min_voice_length + 4);
    if (body > 40) body = 40;
    repeat (body) begin
      send_frame(make_frame(($urandom_range(0, 5) == 0) ? FK_HUSH : FK_VOICED, c));
    end
    // a few utterances stop short of the closing silence
    if ($urandom_range(0, 7) == 0) tail = $urandom_range(0, 2);
    else tail = (c.min_silence == 0) ? 1 : int'(c.min_silence);
    // no frame can be loud, so no segment needs closing
    if (c.energy_high == EnergyTop) tail = 0;
    repeat (tail) send_frame(make_frame(FK_HUSH, c));
  endtask

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sed_in_t  script[$];
    sed_cfg_t cur_cfg;
    int       directed_frames;
    int       budget;
    int       start;

    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: small thresholds so each edge is easy to hit
    cur_cfg = '{24'd1000, 24'd500, 16'd100, 24'd200, 16'd50, 8'd2, 16'd3};
    write_config(cur_cfg);
    script = '{
      '{24'd1001, 16'd0},          // loud at index zero: begin clamps
      '{24'd0, 16'd0},
      '{24'd0, 16'd0},             // second quiet drops the short segment
      '{24'd1000, 16'd0},          // energy equal to high: transition only
      '{24'd500, 16'd100},         // both equal to low: silence
      '{24'd0, 16'd101},           // zcr just above: transition
      '{24'd1001, 16'd0},          // opens voice
      '{24'd0, 16'd0},             // tolerated quiet
      '{24'd201, 16'd0},
      '{24'd0, 16'd51},
      '{24'd200, 16'd50},          // second quiet ends a kept segment
      '{24'hFFFFFF, 16'hFFFF},     // ended frame: reports, not evaluated
      '{24'hFFFFFF, 16'h0000},
      '{24'd0, 16'hFFFF},
      '{24'd0, 16'd0},
      '{24'h800000, 16'h8000},
      '{24'h7FFFFF, 16'h7FFF},
      '{24'd0, 16'd0},
      '{24'd0, 16'd0},
      '{24'd0, 16'd0}
    };
    foreach (script[i]) send_frame(script[i]);
    drain();
    directed_frames = frames_sent;

    for (int p = 0; p < 60; p++) begin
      if (p >= 5 && frames_sent - directed_frames >= 550) break;
      budget = 50;
      case (p)
        0: begin
          cur_cfg = '{EnergyHighRst, EnergyLowRst, ZcrLowRst, '0, '0, MinSilRst, MinLenRst};
          budget = 60;
        end
        1: begin
          cur_cfg = '0;
          budget = 40;
        end
        2: begin
          cur_cfg = '1;
          budget = 30;
        end
        3: begin
          cur_cfg = random_cfg();
          cur_cfg.min_silence = 8'hFF;
          budget = 1;
        end
        default: cur_cfg = random_cfg();
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      write_config(cur_cfg);
      start = frames_sent;
      while (frames_sent - start < budget) begin
        if ($urandom_range(0, 6) == 0) send_frame(make_frame(FK_NOISE, cur_cfg));
        else play_utterance(cur_cfg);
      end
      drain();
    end

    drain();
    if (sb.segments_due.size() != 0) begin
      $error("%0d expected segments never came out", sb.segments_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* speech_endpoint_detector.f */
design/sed_pkg.sv
design/sed_cfg_regs.sv
design/speech_endpoint_detector.sv
tb/sv/speech_endpoint_detector_test.sv
